>>> sv/mcf_pkg.sv
// shared types and constants for the midi channel filter
package mcf_pkg;

  // midi byte codes
  localparam logic [7:0] MIDI_SYSEX_START = 8'hF0;
  localparam logic [7:0] MIDI_SYSEX_END   = 8'hF7;
  localparam logic [3:0] MIDI_NIB_SYSTEM  = 4'hF;

  // register map (word index)
  localparam logic [0:0] REG_KEEP_CHANNEL = 1'b0;

  localparam int unsigned CMD_QUEUE_DEPTH = 4;

  // one decoded input item: up to three result bytes plus end info
  typedef struct packed {
    logic [2:0][7:0] data;      // result bytes, slot 0 first
    logic [1:0]      count;     // number of results, 1 to 3
    logic            has_byte;  // 0 for a bare end marker
    logic            last;      // last result of this entry ends the event
    logic [15:0]     length;    // bytes written in the event, valid with last
  } mcf_entry_t;

  // queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } mcf_qstat_t;

endpackage

>>> sv/mcf_queue.sv
// short command queue between the front and back parts
module mcf_queue #(
  parameter int unsigned DEPTH = mcf_pkg::CMD_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mcf_pkg::mcf_entry_t wr_data,
  input  logic               pop,
  output mcf_pkg::mcf_entry_t rd_data,
  output mcf_pkg::mcf_qstat_t stat
);
  import mcf_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mcf_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign rd_data    = slots[rd_ptr];
  assign stat.full  = (fill == CNT_W'(DEPTH));
  assign stat.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !stat.full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("queue pop while empty");
  a_fill_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (fill == $past(fill) + 1'b1))
    else $error("queue fill count did not follow a push");
`endif

endmodule

>>> sv/mcf_front.sv
// front part: accepts bytes, tracks message parsing, queues result entries
module mcf_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [3:0]         keep_channel,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               event_last,
  input  mcf_pkg::mcf_qstat_t qstat,
  output logic               push,
  output mcf_pkg::mcf_entry_t entry
);
  import mcf_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_SYSEX = 2'd1,
    MODE_KEEP  = 2'd2,
    MODE_SKIP  = 2'd3
  } mode_t;

  mode_t       mode, mode_next;
  logic [1:0]  bytes_left, bytes_left_next;
  logic [7:0]  held_status, held_status_next;
  logic [7:0]  held_first_data, held_first_data_next;
  logic [15:0] written_count, written_count_next;

  logic [2:0][7:0] emit;
  logic [1:0]      n_emit;
  logic [16:0]     count_sum;
  logic [15:0]     count_sat;
  logic            accept;
  logic            is_channel;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;
  assign is_channel = in_byte[7] && (in_byte[7:4] != MIDI_NIB_SYSTEM);

  always_comb begin
    mode_next            = mode;
    bytes_left_next      = bytes_left;
    held_status_next     = held_status;
    held_first_data_next = held_first_data;
    emit                 = '0;
    n_emit               = 2'd0;
    unique case (mode)
      MODE_SYSEX: begin
        emit[0] = in_byte;
        n_emit  = 2'd1;
        if (in_byte == MIDI_SYSEX_END) begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_KEEP: begin
        if (bytes_left >= 2'd2) begin
          held_first_data_next = in_byte;
          bytes_left_next      = 2'd1;
        end else begin
          emit[0]         = held_status;
          emit[1]         = held_first_data;
          emit[2]         = in_byte;
          n_emit          = 2'd3;
          bytes_left_next = 2'd0;
          mode_next       = MODE_IDLE;
        end
      end
      MODE_SKIP: begin
        if (bytes_left > 2'd1) begin
          bytes_left_next = bytes_left - 2'd1;
        end else begin
          bytes_left_next = 2'd0;
          mode_next       = MODE_IDLE;
        end
      end
      MODE_IDLE: begin
        if (in_byte == MIDI_SYSEX_START) begin
          emit[0]   = in_byte;
          n_emit    = 2'd1;
          mode_next = MODE_SYSEX;
        end else if (is_channel) begin
          if (in_byte[3:0] == keep_channel) begin
            held_status_next = in_byte;
            mode_next        = MODE_KEEP;
          end else begin
            mode_next = MODE_SKIP;
          end
          bytes_left_next = 2'd2;
        end else begin
          emit[0] = in_byte;
          n_emit  = 2'd1;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase

    // saturating count of bytes written in this event
    count_sum = {1'b0, written_count} + 17'(n_emit);
    count_sat = count_sum[16] ? 16'hFFFF : count_sum[15:0];
    written_count_next = count_sat;

    entry.data     = emit;
    entry.count    = n_emit;
    entry.has_byte = 1'b1;
    entry.last     = event_last;
    entry.length   = count_sat;
    if (event_last && (n_emit == 2'd0)) begin
      entry.count    = 2'd1;
      entry.has_byte = 1'b0;
    end

    if (event_last) begin
      mode_next            = MODE_IDLE;
      bytes_left_next      = 2'd0;
      held_status_next     = '0;
      held_first_data_next = '0;
      written_count_next   = '0;
    end
  end

  assign push = accept && ((n_emit != 2'd0) || event_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_IDLE;
      bytes_left      <= '0;
      held_status     <= '0;
      held_first_data <= '0;
      written_count   <= '0;
    end else if (accept) begin
      mode            <= mode_next;
      bytes_left      <= bytes_left_next;
      held_status     <= held_status_next;
      held_first_data <= held_first_data_next;
      written_count   <= written_count_next;
    end
  end

endmodule

>>> sv/mcf_back.sv
// back part: plays queued entries out as result items, one per cycle while out_ready is high
module mcf_back (
  input  logic               clk,
  input  logic               rst,
  input  mcf_pkg::mcf_entry_t head,
  input  mcf_pkg::mcf_qstat_t qstat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               has_byte,
  output logic               event_end,
  output logic [15:0]        event_length
);
  import mcf_pkg::*;

  logic [1:0] slot;
  logic       load;
  logic       last_slot;

  assign load      = !qstat.empty && (!out_valid || out_ready);
  assign last_slot = (slot == (head.count - 2'd1));
  assign pop       = load && last_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      slot      <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      slot      <= last_slot ? 2'd0 : slot + 2'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= head.data[slot];
      has_byte     <= head.has_byte;
      event_end    <= head.last && last_slot;
      event_length <= (head.last && last_slot) ? head.length : 16'd0;
    end
  end

`ifndef ASSERT_OFF
  a_bare_is_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_byte) |-> event_end)
    else $error("bare marker without event end");
  a_length_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !event_end) |-> (event_length == 16'd0))
    else $error("length on a result that does not end the event");
  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    !qstat.empty |-> (slot < head.count))
    else $error("result slot past entry count");
`endif

endmodule

>>> sv/midi_channel_filter.sv
// top level of the midi channel message filter
//
// Takes MIDI event bytes one item per cycle on the s_axis side while
// s_axis_tready is high, tlast marking the final byte of an event.
// System-exclusive runs from F0 through the first F7 pass unchanged; channel
// messages (status 8x..Ex plus two data bytes) pass whole only when their
// channel equals keep_channel, else they are dropped; any other byte passes.
// A kept message cut off by the event end is dropped. Each event end yields
// a result with tlast set and the saturating count of bytes written for that
// event (a bare end marker with tuser low when the final byte wrote nothing).
// Input accepts one byte per cycle while the queue is not full; results
// leave one per cycle while m_axis_tready is high, so a completed kept
// message, which produces three results from one input byte, can back up
// the command queue (QUEUE_DEPTH entries). Once the queue is full the input
// is held until the head entry has played out and been popped; no item is
// taken in the cycle of that pop. With an empty queue the first result of an
// item is written into the queue, then loaded into the output register.
// keep_channel is written over the APB port at byte address 0 and resets to 0.
module midi_channel_filter #(
  parameter int unsigned QUEUE_DEPTH = mcf_pkg::CMD_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // event_last
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] event_length
  output logic        m_axis_tuser,   // has_byte
  output logic        m_axis_tlast    // event_end
);
  import mcf_pkg::*;

  logic [3:0]  keep_channel;
  logic        reg_hit;
  mcf_entry_t  push_entry;
  mcf_entry_t  head_entry;
  mcf_qstat_t  qstat;
  logic        push;
  logic        pop;
  logic [7:0]  out_byte;
  logic [15:0] event_length;

  // config register: word index from paddr[2], low bits ignored
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_KEEP_CHANNEL);
  assign prdata  = reg_hit ? {28'd0, keep_channel} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_channel <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      keep_channel <= pwdata[3:0];
    end
  end

  // front: parse and classify each byte
  mcf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .keep_channel (keep_channel),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_byte      (s_axis_tdata),
    .event_last   (s_axis_tlast),
    .qstat        (qstat),
    .push         (push),
    .entry        (push_entry)
  );

  // decouples the two sides so each can stall on its own
  mcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (push_entry),
    .pop     (pop),
    .rd_data (head_entry),
    .stat    (qstat)
  );

  // back: serialize each entry into result items
  mcf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head_entry),
    .qstat        (qstat),
    .pop          (pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_byte     (out_byte),
    .has_byte     (m_axis_tuser),
    .event_end    (m_axis_tlast),
    .event_length (event_length)
  );

  assign m_axis_tdata = {event_length, out_byte};

endmodule

>>> dv/tb.sv
// testbench for the midi channel message filter
module tb;
  import mcf_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no item moving on either side
  localparam int LONG_HOLD      = 300;   // receiver hold-off that backs up the input
  localparam int DRAIN_CYCLES   = 4;     // block latency plus margin
  localparam int ITEMS_PER_SET  = 50;    // random items per channel setting

  localparam logic [2:0] ADDR_KEEP_CHANNEL = {REG_KEEP_CHANNEL, 2'b00};
  localparam logic [2:0] ADDR_UNMAPPED     = 3'd4;
  localparam logic [3:0] MIDI_NIB_CHAN_LO  = 4'h8;

  // parser state of the filter, mirrored here
  typedef enum logic [1:0] {
    PM_IDLE,
    PM_SYSEX,
    PM_KEEP,
    PM_SKIP
  } parse_mode_t;

  // one result item as it leaves the block
  typedef struct packed {
    logic [7:0]  data;
    logic        has_byte;
    logic        ends;
    logic [15:0] length;
  } midi_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] in_byte
  logic        s_axis_tlast = 1'b0; // event_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [7:0] out_byte, [23:8] event_length
  logic        m_axis_tuser;        // has_byte
  logic        m_axis_tlast;        // event_end

  midi_channel_filter DUT (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirrored filter state and configuration
  parse_mode_t  mode_q = PM_IDLE;
  logic [1:0]   left_q = '0;
  logic [7:0]   held_status_q = '0;
  logic [7:0]   held_data_q = '0;
  logic [15:0]  written_q = '0;
  logic [3:0]   keep_ch = '0;

  midi_result_t filtered_bytes[$];   // results still owed by the block
  int           mismatches = 0;
  int           items_sent = 0;
  int           idle_cycles = 0;

  // idling knobs and the long hold request, read by the driver processes
  bit           send_idle = 1'b1;
  bit           recv_idle = 1'b1;
  int           hold_requests = 0;
  int           hold_seen = 0;
  int           hold_left = 0;
  int           stall_left = 0;

  // gap length: mostly none or short, now and then long
  function automatic int gap_len(input bit enable);
    int r;
    r = $urandom_range(0, 99);
    if (!enable || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // work out what one accepted byte makes the filter write
  task automatic filter_byte(input logic [7:0] b, input logic last);
    logic [7:0]   emit[3];
    int           n;
    midi_result_t r;
    n = 0;
    case (mode_q)
      PM_SYSEX: begin
        // everything inside sysex passes, the first F7 closes the run
        emit[0] = b;
        n = 1;
        if (b == MIDI_SYSEX_END) mode_q = PM_IDLE;
      end
      PM_KEEP: begin
        if (left_q >= 2'd2) begin
          held_data_q = b;
          left_q = 2'd1;
        end else begin
          // third byte of a kept message releases all three
          emit[0] = held_status_q;
          emit[1] = held_data_q;
          emit[2] = b;
          n = 3;
          left_q = '0;
          mode_q = PM_IDLE;
        end
      end
      PM_SKIP: begin
        if (left_q > 2'd1) begin
          left_q = left_q - 2'd1;
        end else begin
          left_q = '0;
          mode_q = PM_IDLE;
        end
      end
      default: begin
        if (b == MIDI_SYSEX_START) begin
          emit[0] = b;
          n = 1;
          mode_q = PM_SYSEX;
        end else if (b[7:4] >= MIDI_NIB_CHAN_LO && b[7:4] != MIDI_NIB_SYSTEM) begin
          if (b[3:0] == keep_ch) begin
            held_status_q = b;
            mode_q = PM_KEEP;
          end else begin
            mode_q = PM_SKIP;
          end
          left_q = 2'd2;
        end else begin
          emit[0] = b;
          n = 1;
        end
      end
    endcase
    for (int k = 0; k < n; k++) begin
      if (written_q != 16'hFFFF) written_q = written_q + 16'd1;
      r = '{data: emit[k], has_byte: 1'b1, ends: 1'b0, length: '0};
      if (last && k == n - 1) begin
        r.ends = 1'b1;
        r.length = written_q;
      end
      filtered_bytes = {filtered_bytes, r};
    end
    if (last) begin
      // nothing written on the final byte: bare end marker
      if (n == 0) begin
        r = '{data: '0, has_byte: 1'b0, ends: 1'b1, length: written_q};
        filtered_bytes = {filtered_bytes, r};
      end
      mode_q = PM_IDLE;
      left_q = '0;
      held_status_q = '0;
      held_data_q = '0;
      written_q = '0;
    end
  endtask

  // offer one byte, return at the edge where it is taken
  task automatic send_item(input logic [7:0] b, input logic last);
    int gap;
    gap = gap_len(send_idle);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
    items_sent++;
    filter_byte(b, last);
  endtask

  // stop offering and let every owed result come out
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (filtered_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write a register, then read keep_channel back
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    if (addr == ADDR_KEEP_CHANNEL) keep_ch = value[3:0];
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_KEEP_CHANNEL;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    if (prdata !== {28'd0, keep_ch}) begin
      $display("%0t keep_channel readback: expected %h, got %h", $time,
               {28'd0, keep_ch}, prdata);
      mismatches++;
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_channel(input logic [3:0] ch);
    write_reg(ADDR_KEEP_CHANNEL, {28'($urandom), ch});
  endtask

  // one event: well-formed segments, possibly cut short, or plain noise
  task automatic send_event(input bit noisy);
    logic [7:0] seq[$];
    logic [7:0] b;
    int         cut;
    if (noisy) begin
      repeat ($urandom_range(1, 6)) seq = {seq, 8'($urandom)};
    end else begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            // channel message, on the kept channel about half the time
            b = {4'($urandom_range(8, 14)),
                 ($urandom_range(0, 1) ? keep_ch : 4'($urandom))};
            seq = {seq, b};
            seq = {seq, 8'($urandom_range(0, 127))};
            seq = {seq, 8'($urandom_range(0, 127))};
          end
          4, 5: begin
            seq = {seq, MIDI_SYSEX_START};
            repeat ($urandom_range(0, 5)) seq = {seq, 8'($urandom)};
            if ($urandom_range(0, 4) != 0) seq = {seq, MIDI_SYSEX_END};
          end
          6, 7: seq = {seq, 8'($urandom_range(0, 127))};
          default: seq = {seq, {MIDI_NIB_SYSTEM, 4'($urandom)}};
        endcase
      end
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(0, seq.size() - 1);
        seq = seq[0:cut];
      end
    end
    foreach (seq[i]) send_item(seq[i], i == seq.size() - 1);
  endtask

  task automatic test_directed();
    // kept note on, channel 0 from reset
    send_item(8'h90, 1'b0); send_item(8'h3C, 1'b0); send_item(8'h7F, 1'b1);
    // other channel dropped, bare end marker
    send_item(8'h91, 1'b0); send_item(8'h3C, 1'b0); send_item(8'h7F, 1'b1);
    // sysex carrying a status byte, then a stray data byte after F7
    send_item(MIDI_SYSEX_START, 1'b0); send_item(8'h7E, 1'b0);
    send_item(8'h90, 1'b0); send_item(MIDI_SYSEX_END, 1'b0); send_item(8'h00, 1'b1);
    // sysex with no closing F7
    send_item(MIDI_SYSEX_START, 1'b0); send_item(8'h11, 1'b1);
    // kept message cut short after one data byte and after the status
    send_item(8'hE0, 1'b0); send_item(8'h00, 1'b1);
    send_item(8'hB0, 1'b1);
    // dropped message cut short
    send_item(8'hA3, 1'b1);
    // lone system byte and lone data byte
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b1);
    // kept message completed mid event, then a system byte ends it
    send_item(8'h80, 1'b0); send_item(8'h00, 1'b0); send_item(8'h00, 1'b0);
    send_item(8'hF8, 1'b1);
    // channel 15 dropped while channel 0 is kept
    send_item(8'hEF, 1'b0); send_item(8'hFF, 1'b0); send_item(8'hFF, 1'b1);
    wait_drain();
  endtask

  task automatic test_config();
    set_channel(4'hF);
    // unmapped register must leave keep_channel alone
    write_reg(ADDR_UNMAPPED, 32'hFFFF_FFF3);
    send_item(8'hEF, 1'b0); send_item(8'hFF, 1'b0); send_item(8'hFF, 1'b1);
    send_item(8'hCF, 1'b0); send_item(8'h12, 1'b0); send_item(8'h34, 1'b1);
    send_item(8'hC0, 1'b0); send_item(8'h12, 1'b0); send_item(8'h34, 1'b1);
    wait_drain();
    set_channel(4'h0);
    send_item(8'hC0, 1'b0); send_item(8'h12, 1'b0); send_item(8'h34, 1'b1);
    wait_drain();
  endtask

  task automatic test_random_events();
    logic [3:0] channels[4];
    int         target;
    channels = '{4'h0, 4'hF, 4'($urandom), 4'($urandom)};
    foreach (channels[i]) begin
      set_channel(channels[i]);
      // one setting runs with no idling on either side
      send_idle = (i != 2);
      recv_idle = (i != 2);
      target = items_sent + ITEMS_PER_SET;
      while (items_sent < target) send_event($urandom_range(0, 6) == 0);
      wait_drain();
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  task automatic test_output_hold();
    // receiver holds off while kept messages keep coming
    send_idle = 1'b0;
    hold_requests++;
    repeat (15) begin
      send_item({MIDI_NIB_CHAN_LO, keep_ch}, 1'b0);
      send_item(8'($urandom_range(0, 127)), 1'b0);
      send_item(8'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
    end
    send_idle = 1'b1;
    // sender pauses until everything has come out
    wait_drain();
  endtask

  // receiver: random stalls plus the requested long hold
  always @(posedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left = gap_len(recv_idle);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // check each result against the oldest owed one, sampled mid cycle
  always @(negedge clk) begin
    midi_result_t got;
    midi_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{data: m_axis_tdata[7:0], has_byte: m_axis_tuser, ends: m_axis_tlast,
              length: m_axis_tdata[23:8]};
      if (filtered_bytes.size() == 0) begin
        $display("%0t unexpected result: expected none, ",
                 "got byte=%h has=%b end=%b len=%0d",
                 $time, got.data, got.has_byte, got.ends, got.length);
        mismatches++;
      end else begin
        want = filtered_bytes.pop_front();
        if (got.data !== want.data || got.has_byte !== want.has_byte ||
            got.ends !== want.ends || got.length !== want.length) begin
          $display("%0t result: expected byte=%h has=%b end=%b len=%0d, ",
                   "got byte=%h has=%b end=%b len=%0d",
                   $time, want.data, want.has_byte, want.ends, want.length,
                   got.data, got.has_byte, got.ends, got.length);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles where nothing moves
  always @(negedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config();
    test_random_events();
    test_output_hold();
    if (filtered_bytes.size() != 0) begin
      $display("%0t results left over: expected none, got %0d owed", $time,
               filtered_bytes.size());
      mismatches++;
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
